### rtl/poct_pkg.sv
// Package for the priority-ordered completion table.
// Holds the field widths, command and status codes, and the entry and state types.
package poct_pkg;

    localparam int P_DEPTH     = 16;
    localparam int TAG_W       = 24;
    localparam int PRIO_W      = 8;
    localparam int BURST_W     = 16;
    localparam int COMP_W      = 20;
    localparam int STATUS_W    = 2;

    localparam logic [COMP_W-1:0] COMPLETION_MAX = {COMP_W{1'b1}};

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LIST   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SHIFT = 4'b0010,
        S_START = 4'b0100,
        S_LIST  = 4'b1000
    } t_state;

endpackage

### rtl/poct_intf.sv
// Channel interfaces of the priority-ordered completion table: job in, entry out.
// Depends on poct_pkg for the field widths.
interface poct_job_if import poct_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [TAG_W-1:0]   job_tag;
    logic [PRIO_W-1:0]  job_priority;
    logic [BURST_W-1:0] job_burst;

    modport source (output valid, cmd, job_tag, job_priority, job_burst, input ready);
    modport sink   (input valid, cmd, job_tag, job_priority, job_burst, output ready);
endinterface

interface poct_entry_if import poct_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [TAG_W-1:0]    entry_tag;
    logic [PRIO_W-1:0]   entry_priority;
    logic [BURST_W-1:0]  entry_burst;
    logic [COMP_W-1:0]   entry_completion;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, entry_tag, entry_priority, entry_burst, entry_completion,
                    status, last, input ready);
    modport sink   (input valid, entry_tag, entry_priority, entry_burst, entry_completion,
                    status, last, output ready);
endinterface

### rtl/poct_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while no read is enabled. No dependencies.
module poct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/priority_ordered_completion_table.sv
// Priority-ordered completion table: sorted job store in one RAM, walked per command.
// Insert: accept, then move each entry of greater priority value up one slot and place the
// job in the freed slot; start: read the first entry; list: one beat per cycle while the
// output is not stalled. A new command is accepted once the last beat is registered.
// Reset clears the state, the entry count and the output valid; the RAM is not cleared.
// Depends on poct_pkg, poct_intf and poct_ram.
module priority_ordered_completion_table import poct_pkg::*; #(
    parameter int DEPTH = P_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    poct_job_if.sink      i_job,
    poct_entry_if.source  o_entry
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_k, n_k;
    logic [AW-1:0]        r_idx, n_idx;
    t_entry               r_job, n_job;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic [COMP_W-1:0]    r_sum, n_sum;

    logic                 r_ovalid, n_ovalid;
    t_entry               r_oent, n_oent;
    logic [COMP_W-1:0]    r_ocomp, n_ocomp;
    logic [STATUS_W-1:0]  r_ostat, n_ostat;
    logic                 r_olast, n_olast;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    t_entry               ram_wdata;
    logic [$bits(t_entry)-1:0] ram_rdata;
    t_entry               rd;

    logic                 out_free;
    logic [COMP_W:0]      sum_ext;
    logic [COMP_W-1:0]    sum_sat;
    logic                 is_last;

    poct_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd       = t_entry'(ram_rdata);
    assign out_free = !r_ovalid || o_entry.ready;
    assign sum_ext  = {1'b0, r_sum} + (COMP_W + 1)'(rd.burst);
    assign sum_sat  = sum_ext[COMP_W] ? COMPLETION_MAX : sum_ext[COMP_W-1:0];
    assign is_last  = (CW'(r_idx) + CW'(1)) == r_count;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_k       = r_k;
        n_idx     = r_idx;
        n_job     = r_job;
        n_status  = r_status;
        n_sum     = r_sum;
        n_ovalid  = r_ovalid && !o_entry.ready;
        n_oent    = r_oent;
        n_ocomp   = r_ocomp;
        n_ostat   = r_ostat;
        n_olast   = r_olast;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_job;
        ram_re    = 1'b0;
        ram_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_job.valid) begin
                    n_job.tag   = i_job.job_tag;
                    n_job.prio  = i_job.job_priority;
                    n_job.burst = i_job.job_burst;
                    if (i_job.cmd == CMD_INSERT && r_count != CW'(DEPTH)) begin
                        n_status = ST_OK;
                        n_k      = r_count[AW-1:0];
                        if (r_count != '0) begin
                            ram_re    = 1'b1;
                            ram_raddr = AW'(r_count - CW'(1));
                        end
                        n_state = S_SHIFT;
                    end else begin
                        n_status = (i_job.cmd == CMD_INSERT) ? ST_FULL : ST_OK;
                        n_state  = S_START;
                    end
                end
            end
            S_SHIFT: begin
                if (r_k == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = r_job;
                    n_count   = r_count + CW'(1);
                    n_state   = S_START;
                end else if (rd.prio > r_job.prio) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_k;
                    ram_wdata = rd;
                    n_k       = r_k - AW'(1);
                    if (r_k != AW'(1)) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_k - AW'(2);
                    end
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_k;
                    ram_wdata = r_job;
                    n_count   = r_count + CW'(1);
                    n_state   = S_START;
                end
            end
            S_START: begin
                if (r_count == '0) begin
                    if (out_free) begin
                        n_ovalid = 1'b1;
                        n_oent   = '0;
                        n_ocomp  = '0;
                        n_ostat  = ST_EMPTY;
                        n_olast  = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = '0;
                    n_idx     = '0;
                    n_sum     = '0;
                    n_state   = S_LIST;
                end
            end
            S_LIST: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oent   = rd;
                    n_ocomp  = sum_sat;
                    n_ostat  = r_status;
                    n_olast  = is_last;
                    n_sum    = sum_sat;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_idx + AW'(1);
                        n_idx     = r_idx + AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_idx    <= n_idx;
        r_job    <= n_job;
        r_status <= n_status;
        r_sum    <= n_sum;
        r_oent   <= n_oent;
        r_ocomp  <= n_ocomp;
        r_ostat  <= n_ostat;
        r_olast  <= n_olast;
    end

    assign i_job.ready              = (r_state == S_IDLE);
    assign o_entry.valid            = r_ovalid;
    assign o_entry.entry_tag        = r_oent.tag;
    assign o_entry.entry_priority   = r_oent.prio;
    assign o_entry.entry_burst      = r_oent.burst;
    assign o_entry.entry_completion = r_ocomp;
    assign o_entry.status           = r_ostat;
    assign o_entry.last             = r_olast;

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("RAM read and write hit the same entry");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> (r_count == $past(r_count) + CW'(1)))
        else $error("entry count moved by other than one");

    a_shift_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_count < CW'(DEPTH)))
        else $error("insert walk started on a full table");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_entry.ready) |=> (r_ovalid && $stable(r_ocomp)))
        else $error("held beat overwritten");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for priority_ordered_completion_table.
// It drives job commands, predicts each ordered listing and checks every entry beat.
// Depends on poct_pkg, poct_intf and the block's RTL.
module testbench;
    import poct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_TICKS = 2 * P_DEPTH + 8;
    localparam int PHASE_ITEMS  = 70;

    typedef struct packed {
        logic               cmd;
        logic [TAG_W-1:0]   tag;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
    } job_t;

    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [PRIO_W-1:0]   prio;
        logic [BURST_W-1:0]  burst;
        logic [COMP_W-1:0]   completion;
        logic [STATUS_W-1:0] status;
        logic                last;
    } entry_beat_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    poct_job_if   job_ch ();
    poct_entry_if entry_ch ();

    priority_ordered_completion_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_ch),
        .o_entry (entry_ch)
    );

    t_entry      job_table[P_DEPTH];
    int          job_count = 0;
    job_t        job_backlog[$];
    entry_beat_t expected_beats[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 20;
    int          recv_idle_pct = 61;
    int          hold_left = 0;
    logic        hold_req = 1'b0;

    always #6 i_clk = ~i_clk;

    // Insert (or reject) the job, then queue the full ordered listing.
    function automatic void schedule_job(input job_t j);
        logic [STATUS_W-1:0] st;
        int                  pos;
        int                  k;
        int unsigned         running;
        entry_beat_t         b;
        st = ST_OK;
        running = 0;
        if (j.cmd == CMD_INSERT) begin
            if (job_count >= P_DEPTH) begin
                st = ST_FULL;
            end else begin
                pos = 0;
                while (pos < job_count && job_table[pos].prio <= j.prio) pos++;
                for (k = job_count; k > pos; k--) job_table[k] = job_table[k-1];
                job_table[pos] = '{tag: j.tag, prio: j.prio, burst: j.burst};
                job_count++;
            end
        end
        if (job_count == 0) begin
            expected_beats.push_back('{tag: '0, prio: '0, burst: '0, completion: '0,
                                       status: ST_EMPTY, last: 1'b1});
        end else begin
            for (k = 0; k < job_count; k++) begin
                running += job_table[k].burst;
                if (running > COMPLETION_MAX) running = COMPLETION_MAX;
                b.tag        = job_table[k].tag;
                b.prio       = job_table[k].prio;
                b.burst      = job_table[k].burst;
                b.completion = running[COMP_W-1:0];
                b.status     = st;
                b.last       = (k + 1 == job_count);
                expected_beats.push_back(b);
            end
        end
    endfunction

    function automatic void check_field(input string fname, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            error_count++;
        end
    endfunction

    function automatic job_t random_job();
        job_t j;
        j.cmd   = ($urandom_range(99) < 75) ? CMD_INSERT : CMD_LIST;
        j.tag   = TAG_W'($urandom);
        j.prio  = PRIO_W'($urandom);
        j.burst = BURST_W'($urandom);
        return j;
    endfunction

    // Driver: hold each beat until accepted, then advance the backlog.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            job_ch.valid <= 1'b0;
        end else begin
            if (job_ch.valid && job_ch.ready) begin
                schedule_job('{cmd: job_ch.cmd, tag: job_ch.job_tag,
                               prio: job_ch.job_priority, burst: job_ch.job_burst});
            end
            if (!job_ch.valid || job_ch.ready) begin
                if (job_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    job_t j;
                    j = job_backlog.pop_front();
                    job_ch.valid        <= 1'b1;
                    job_ch.cmd          <= j.cmd;
                    job_ch.job_tag      <= j.tag;
                    job_ch.job_priority <= j.prio;
                    job_ch.job_burst    <= j.burst;
                end else begin
                    job_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted beat against the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entry_ch.ready <= 1'b0;
        end else begin
            if (entry_ch.valid && entry_ch.ready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual tag %0h last %0b",
                             $time, entry_ch.entry_tag, entry_ch.last);
                    error_count++;
                end else begin
                    entry_beat_t e;
                    e = expected_beats.pop_front();
                    check_field("entry_tag", e.tag, entry_ch.entry_tag);
                    check_field("entry_priority", e.prio, entry_ch.entry_priority);
                    check_field("entry_burst", e.burst, entry_ch.entry_burst);
                    check_field("entry_completion", e.completion, entry_ch.entry_completion);
                    check_field("status", e.status, entry_ch.status);
                    check_field("last", e.last, entry_ch.last);
                end
            end
            if (hold_left > 0) begin
                hold_left      <= hold_left - 1;
                entry_ch.ready <= 1'b0;
            end else if (hold_req) begin
                hold_left      <= HOLD_CYCLES;
                entry_ch.ready <= 1'b0;
            end else begin
                entry_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (job_backlog.size() != 0 || job_ch.valid || expected_beats.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int i;
        job_ch.valid        = 1'b0;
        job_ch.cmd          = CMD_LIST;
        job_ch.job_tag      = '0;
        job_ch.job_priority = '0;
        job_ch.job_burst    = '0;
        entry_ch.ready      = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty listing, field extremes, ties, fill to full, rejected insert.
        job_backlog.push_back('{cmd: CMD_LIST, tag: 24'h123456, prio: 8'd7, burst: 16'd9});
        job_backlog.push_back('{cmd: CMD_INSERT, tag: 24'hFFFFFF, prio: 8'hFF, burst: 16'hFFFF});
        job_backlog.push_back('{cmd: CMD_INSERT, tag: 24'h000000, prio: 8'h00, burst: 16'h0000});
        job_backlog.push_back('{cmd: CMD_INSERT, tag: 24'hABCDEF, prio: 8'hFF, burst: 16'h0001});
        job_backlog.push_back('{cmd: CMD_INSERT, tag: 24'h414243, prio: 8'h00, burst: 16'h8000});
        job_backlog.push_back('{cmd: CMD_LIST, tag: 24'h0, prio: 8'h0, burst: 16'h0});
        for (i = 0; i < P_DEPTH - 4; i++) begin
            job_backlog.push_back('{cmd: CMD_INSERT, tag: TAG_W'(24'h4A3030 + i),
                                    prio: PRIO_W'((i * 53) % 256),
                                    burst: BURST_W'(16'hFFFF - i)});
        end
        job_backlog.push_back('{cmd: CMD_INSERT, tag: 24'h5A5A5A, prio: 8'h01, burst: 16'h1234});
        job_backlog.push_back('{cmd: CMD_LIST, tag: 24'hFFFFFF, prio: 8'hFF, burst: 16'hFFFF});
        wait_drained();

        for (i = 0; i < PHASE_ITEMS; i++) job_backlog.push_back(random_job());
        wait_drained();

        send_idle_pct = 61;
        recv_idle_pct = 20;
        for (i = 0; i < PHASE_ITEMS; i++) job_backlog.push_back(random_job());
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (i = 0; i < PHASE_ITEMS; i++) job_backlog.push_back(random_job());
        @(posedge i_clk);
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        wait_drained();

        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (error_count == 0 && expected_beats.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
